[sv/random_prim_maze_carver_assert.svh]
// Assertion macros shared by the checker
`ifndef RANDOM_PRIM_MAZE_CARVER_ASSERT_SVH
`define RANDOM_PRIM_MAZE_CARVER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge
`define RPMC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rpmc assertion failed");

// Next-cycle implication
`define RPMC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rpmc assertion failed");

`endif

[sv/rpmc_pkg.sv]
package rpmc_pkg;

   // Grid and list geometry
   localparam int MAX_DIM   = 32;
   localparam int COORD_W   = $clog2(MAX_DIM);
   localparam int DIM_W     = COORD_W + 1;
   localparam int CELL_W    = 2 * COORD_W;
   localparam int NCELLS    = MAX_DIM * MAX_DIM;
   localparam int MAX_WALLS = 4096;
   localparam int LIST_AW   = $clog2(MAX_WALLS);
   localparam int COUNT_W   = LIST_AW + 1;
   localparam int ENTRY_W   = CELL_W + 2;
   localparam int RAND_W    = 31;
   localparam int DIVCNT_W  = $clog2(RAND_W);

   typedef enum logic [1:0] {
      DIR_UP    = 2'd0,
      DIR_DOWN  = 2'd1,
      DIR_LEFT  = 2'd2,
      DIR_RIGHT = 2'd3
   } dir_type;

   typedef enum logic [2:0] {
      RES_STARTED      = 3'd0,
      RES_EDGE_REMOVED = 3'd1,
      RES_CARVED       = 3'd2,
      RES_VISITED      = 3'd3,
      RES_IGNORED      = 3'd4
   } res_status_type;

   typedef enum logic [0:0] {
      REQ_START = 1'b0,
      REQ_DRAW  = 1'b1
   } req_cmd_type;

   typedef enum logic [0:0] {
      CSR_GRID_ROWS = 1'b0,
      CSR_GRID_COLS = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_RST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_CLEAR,
      ST_INIT,
      ST_DIV,
      ST_LIST_RD,
      ST_DECODE,
      ST_MAP_WAIT,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_CARVE_WALL,
      ST_CARVE_FAR,
      ST_ADD_RD,
      ST_ADD_CHK,
      ST_FINISH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic req_ready;
      logic clr_step;
      logic dispatch;
      logic start_init;
      logic div_start;
      logic list_rd;
      logic decode;
      logic map_wait;
      logic shift_wr;
      logic shift_end;
      logic carve_wall;
      logic carve_far;
      logic add_rd;
      logic add_chk;
      logic finish;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_start;
      logic draw_ok;
      logic clr_last;
      logic div_done;
      logic shift_last;
      logic carve;
      logic add_last;
      logic rsp_free;
   } dp_sts_type;

   // Neighbour visiting order for one cell
   typedef struct packed {
      logic [2:0]       num;
      dir_type [3:0]    dirs;
   } plan_type;

endpackage

[sv/rpmc_div.sv]
// Restoring divider, one quotient bit a cycle; only the remainder is kept
module rpmc_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [rpmc_pkg::RAND_W-1:0]        dividend,
   input  logic [rpmc_pkg::COUNT_W-1:0]       divisor,
   output logic                               done,
   output logic [rpmc_pkg::LIST_AW-1:0]       remainder
);

   logic [rpmc_pkg::COUNT_W:0]        rem_ff, rem_in;
   logic [rpmc_pkg::RAND_W-1:0]       dvd_ff, dvd_in;
   logic [rpmc_pkg::COUNT_W-1:0]      dvs_ff, dvs_in;
   logic [rpmc_pkg::DIVCNT_W-1:0]     cnt_ff, cnt_in;
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [rpmc_pkg::COUNT_W:0]        trial;

   // One restoring step
   always_comb begin
      trial   = {rem_ff[rpmc_pkg::COUNT_W-1:0], dvd_ff[rpmc_pkg::RAND_W-1]};
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
         end else begin
            rem_in = trial;
         end
         dvd_in = {dvd_ff[rpmc_pkg::RAND_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == rpmc_pkg::DIVCNT_W'(rpmc_pkg::RAND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[rpmc_pkg::LIST_AW-1:0];

endmodule

[sv/rpmc_dp.sv]
// Datapath: cell map, wall list, counters and the result register
module rpmc_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  rpmc_pkg::dp_cmd_type               cmd,
   output rpmc_pkg::dp_sts_type               sts,
   input  logic                               req_valid,
   input  logic                               req_cmd,
   input  logic [4:0]                         req_start_row,
   input  logic [4:0]                         req_start_col,
   input  logic [30:0]                        req_random_value,
   input  logic                               csr_valid,
   input  logic                               csr_index,
   input  logic [5:0]                         csr_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [2:0]                         rsp_status,
   output logic [4:0]                         rsp_wall_row,
   output logic [4:0]                         rsp_wall_col,
   output logic [4:0]                         rsp_far_row,
   output logic [4:0]                         rsp_far_col,
   output logic [12:0]                        rsp_walls_pending,
   output logic                               rsp_done_res,
   output logic [4:0]                         rsp_goal_row,
   output logic [4:0]                         rsp_goal_col
);

   localparam int CW = rpmc_pkg::COORD_W;
   localparam int DW = rpmc_pkg::DIM_W;
   localparam int EW = rpmc_pkg::CELL_W;

   // Clamp a size register to 2..MAX_DIM
   function automatic logic [DW-1:0] eff_dim(input logic [DW-1:0] v);
      logic [DW-1:0] r;
      r = v;
      if (v < DW'(2)) r = DW'(2);
      if (v > DW'(rpmc_pkg::MAX_DIM)) r = DW'(rpmc_pkg::MAX_DIM);
      return r;
   endfunction

   // Neighbour order by corner, edge or centre position
   function automatic rpmc_pkg::plan_type wall_plan(input logic [CW-1:0] r,
                                                    input logic [CW-1:0] c,
                                                    input logic [DW-1:0] h,
                                                    input logic [DW-1:0] w);
      rpmc_pkg::plan_type p;
      logic [DW-1:0] hm1, wm1;
      logic top, bot, lft, rgt;
      hm1 = h - 1'b1;
      wm1 = w - 1'b1;
      top = (r == '0);
      bot = (r == hm1[CW-1:0]);
      lft = (c == '0);
      rgt = (c == wm1[CW-1:0]);
      p.num  = 3'd0;
      p.dirs = {rpmc_pkg::DIR_UP, rpmc_pkg::DIR_UP, rpmc_pkg::DIR_UP, rpmc_pkg::DIR_UP};
      if (top && lft) begin
         p.num = 3'd2; p.dirs[0] = rpmc_pkg::DIR_DOWN; p.dirs[1] = rpmc_pkg::DIR_RIGHT;
      end else if (bot && rgt) begin
         p.num = 3'd2; p.dirs[0] = rpmc_pkg::DIR_UP; p.dirs[1] = rpmc_pkg::DIR_LEFT;
      end else if (bot && lft) begin
         p.num = 3'd2; p.dirs[0] = rpmc_pkg::DIR_UP; p.dirs[1] = rpmc_pkg::DIR_RIGHT;
      end else if (top && rgt) begin
         p.num = 3'd2; p.dirs[0] = rpmc_pkg::DIR_LEFT; p.dirs[1] = rpmc_pkg::DIR_DOWN;
      end else if (top) begin
         p.num = 3'd3; p.dirs[0] = rpmc_pkg::DIR_DOWN; p.dirs[1] = rpmc_pkg::DIR_LEFT;
         p.dirs[2] = rpmc_pkg::DIR_RIGHT;
      end else if (bot) begin
         p.num = 3'd3; p.dirs[0] = rpmc_pkg::DIR_UP; p.dirs[1] = rpmc_pkg::DIR_LEFT;
         p.dirs[2] = rpmc_pkg::DIR_RIGHT;
      end else if (rgt) begin
         p.num = 3'd3; p.dirs[0] = rpmc_pkg::DIR_LEFT; p.dirs[1] = rpmc_pkg::DIR_UP;
         p.dirs[2] = rpmc_pkg::DIR_DOWN;
      end else if (lft) begin
         p.num = 3'd3; p.dirs[0] = rpmc_pkg::DIR_RIGHT; p.dirs[1] = rpmc_pkg::DIR_UP;
         p.dirs[2] = rpmc_pkg::DIR_DOWN;
      end else begin
         p.num = 3'd4; p.dirs[0] = rpmc_pkg::DIR_UP; p.dirs[1] = rpmc_pkg::DIR_DOWN;
         p.dirs[2] = rpmc_pkg::DIR_LEFT; p.dirs[3] = rpmc_pkg::DIR_RIGHT;
      end
      return p;
   endfunction

   // Configuration registers
   logic [DW-1:0] rows_ff, rows_in, cols_ff, cols_in;
   // Latched request
   rpmc_pkg::req_cmd_type         cmd_ff, cmd_in;
   logic [CW-1:0]                 sr_ff, sr_in, sc_ff, sc_in;
   logic [rpmc_pkg::RAND_W-1:0]   rv_ff, rv_in;
   // Carving state
   logic                          active_ff, active_in;
   logic [rpmc_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [EW-1:0]                 goal_ff, goal_in;
   logic [EW-1:0]                 clr_ff, clr_in;
   rpmc_pkg::res_status_type      res_st_ff, res_st_in;
   logic [EW-1:0]                 wall_ff, wall_in;
   logic [CW-1:0]                 far_r_ff, far_r_in, far_c_ff, far_c_in;
   logic [rpmc_pkg::LIST_AW-1:0]  idx_ff, idx_in;
   logic [EW-1:0]                 cur_ff, cur_in;
   logic [2:0]                    j_ff, j_in;
   // Result register
   logic                          rv_out_ff, rv_out_in;
   rpmc_pkg::res_status_type      o_st_ff, o_st_in;
   logic [EW-1:0]                 o_wall_ff, o_wall_in;
   logic [CW-1:0]                 o_fr_ff, o_fr_in, o_fc_ff, o_fc_in;
   logic [rpmc_pkg::COUNT_W-1:0]  o_pend_ff, o_pend_in;
   logic                          o_done_ff, o_done_in;
   logic [EW-1:0]                 o_goal_ff, o_goal_in;

   // Memories: 1 bit per cell (1 = barrier), wall entries {cell, dir}
   logic                          map_mem [rpmc_pkg::NCELLS];
   logic                          map_q_ff;
   logic [EW-1:0]                 map_addr;
   logic                          map_we, map_wd;
   logic [rpmc_pkg::ENTRY_W-1:0]  list_mem [rpmc_pkg::MAX_WALLS];
   logic [rpmc_pkg::ENTRY_W-1:0]  list_q_ff;
   logic [rpmc_pkg::LIST_AW-1:0]  list_raddr, list_waddr;
   logic                          list_we;
   logic [rpmc_pkg::ENTRY_W-1:0]  list_wd;

   logic                          accept;
   logic [DW-1:0]                 h, w, hm1, wm1;
   logic [CW-1:0]                 sr_sat, sc_sat;
   logic                          div_done;
   logic [rpmc_pkg::LIST_AW-1:0]  div_rem;
   // Decode of the chosen entry
   logic [EW-1:0]                 e_cell;
   logic [CW-1:0]                 e_r, e_c;
   rpmc_pkg::dir_type             e_d;
   logic [DW-1:0]                 nr6, nc6;
   logic                          outside;
   // Neighbour for append
   rpmc_pkg::plan_type            plan;
   rpmc_pkg::dir_type             nb_d;
   logic [CW-1:0]                 cur_r, cur_c, nb_r, nb_c;
   logic                          nb_ok, push_ok;

   assign accept = req_valid && cmd.req_ready;
   assign h   = eff_dim(rows_ff);
   assign w   = eff_dim(cols_ff);
   assign hm1 = h - 1'b1;
   assign wm1 = w - 1'b1;
   assign sr_sat = ({1'b0, sr_ff} >= h) ? hm1[CW-1:0] : sr_ff;
   assign sc_sat = ({1'b0, sc_ff} >= w) ? wm1[CW-1:0] : sc_ff;

   rpmc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (rv_ff),
      .divisor   (count_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   // Far cell of the chosen wall
   always_comb begin
      e_cell = list_q_ff[rpmc_pkg::ENTRY_W-1:2];
      e_r    = e_cell[EW-1:CW];
      e_c    = e_cell[CW-1:0];
      e_d    = rpmc_pkg::dir_type'(list_q_ff[1:0]);
      nr6    = {1'b0, e_r};
      nc6    = {1'b0, e_c};
      outside = 1'b0;
      case (e_d)
         rpmc_pkg::DIR_UP: begin
            outside = (e_r == '0);
            nr6 = {1'b0, e_r} - 1'b1;
         end
         rpmc_pkg::DIR_DOWN:  nr6 = {1'b0, e_r} + 1'b1;
         rpmc_pkg::DIR_LEFT: begin
            outside = (e_c == '0);
            nc6 = {1'b0, e_c} - 1'b1;
         end
         rpmc_pkg::DIR_RIGHT: nc6 = {1'b0, e_c} + 1'b1;
         default: outside = 1'b1;
      endcase
      if (nr6 >= h || nc6 >= w) outside = 1'b1;
   end

   // Neighbour of the current cell in the planned direction
   always_comb begin
      cur_r = cur_ff[EW-1:CW];
      cur_c = cur_ff[CW-1:0];
      plan  = wall_plan(cur_r, cur_c, h, w);
      nb_d  = plan.dirs[j_ff[1:0]];
      nb_r  = cur_r;
      nb_c  = cur_c;
      nb_ok = 1'b0;
      case (nb_d)
         rpmc_pkg::DIR_UP: begin
            nb_ok = (cur_r != '0);
            nb_r  = cur_r - 1'b1;
         end
         rpmc_pkg::DIR_DOWN: begin
            nb_ok = (cur_r != '1);
            nb_r  = cur_r + 1'b1;
         end
         rpmc_pkg::DIR_LEFT: begin
            nb_ok = (cur_c != '0);
            nb_c  = cur_c - 1'b1;
         end
         rpmc_pkg::DIR_RIGHT: begin
            nb_ok = (cur_c != '1);
            nb_c  = cur_c + 1'b1;
         end
         default: nb_ok = 1'b0;
      endcase
      push_ok = nb_ok && map_q_ff &&
                (count_ff < rpmc_pkg::COUNT_W'(rpmc_pkg::MAX_WALLS));
   end

   // Map port selection
   always_comb begin
      map_addr = '0;
      map_we   = 1'b0;
      map_wd   = 1'b0;
      if (cmd.clr_step) begin
         map_addr = clr_ff;
         map_we   = 1'b1;
         map_wd   = 1'b1;
      end else if (cmd.start_init) begin
         map_addr = {sr_sat, sc_sat};
         map_we   = 1'b1;
      end else if (cmd.decode) begin
         map_addr = {nr6[CW-1:0], nc6[CW-1:0]};
      end else if (cmd.carve_wall) begin
         map_addr = wall_ff;
         map_we   = 1'b1;
      end else if (cmd.carve_far) begin
         map_addr = {far_r_ff, far_c_ff};
         map_we   = 1'b1;
      end else if (cmd.add_rd) begin
         map_addr = {nb_r, nb_c};
      end
   end

   // Wall list port selection
   always_comb begin
      list_raddr = idx_ff + 1'b1;
      list_waddr = idx_ff;
      list_we    = 1'b0;
      list_wd    = list_q_ff;
      if (cmd.list_rd) begin
         list_raddr = div_rem;
      end
      if (cmd.shift_wr) begin
         list_we = 1'b1;
      end else if (cmd.add_chk && push_ok) begin
         list_we    = 1'b1;
         list_waddr = count_ff[rpmc_pkg::LIST_AW-1:0];
         list_wd    = {nb_r, nb_c, nb_d};
      end
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_addr] <= map_wd;
      end
      map_q_ff <= map_mem[map_addr];
   end

   always_ff @(posedge clock) begin
      if (list_we) begin
         list_mem[list_waddr] <= list_wd;
      end
      list_q_ff <= list_mem[list_raddr];
   end

   // Next-state of the working registers
   always_comb begin
      rows_in   = rows_ff;
      cols_in   = cols_ff;
      cmd_in    = cmd_ff;
      sr_in     = sr_ff;
      sc_in     = sc_ff;
      rv_in     = rv_ff;
      active_in = active_ff;
      count_in  = count_ff;
      goal_in   = goal_ff;
      clr_in    = clr_ff;
      res_st_in = res_st_ff;
      wall_in   = wall_ff;
      far_r_in  = far_r_ff;
      far_c_in  = far_c_ff;
      idx_in    = idx_ff;
      cur_in    = cur_ff;
      j_in      = j_ff;

      if (csr_valid) begin
         if (csr_index == rpmc_pkg::CSR_GRID_ROWS) rows_in = csr_data;
         else cols_in = csr_data;
      end
      if (accept) begin
         cmd_in = rpmc_pkg::req_cmd_type'(req_cmd);
         sr_in  = req_start_row;
         sc_in  = req_start_col;
         rv_in  = req_random_value;
      end
      if (cmd.clr_step) clr_in = clr_ff + 1'b1;
      if (cmd.dispatch) begin
         wall_in  = '0;
         far_r_in = '0;
         far_c_in = '0;
         if (cmd_ff == rpmc_pkg::REQ_START) begin
            res_st_in = rpmc_pkg::RES_STARTED;
         end else if (!(active_ff && count_ff != '0)) begin
            res_st_in = rpmc_pkg::RES_IGNORED;
            active_in = 1'b0;
         end
      end
      if (cmd.start_init) begin
         count_in  = '0;
         goal_in   = {sr_sat, sc_sat};
         cur_in    = {sr_sat, sc_sat};
         j_in      = '0;
         active_in = 1'b1;
      end
      if (cmd.decode) begin
         wall_in = e_cell;
         idx_in  = div_rem;
         if (outside) begin
            res_st_in = rpmc_pkg::RES_EDGE_REMOVED;
         end else begin
            res_st_in = rpmc_pkg::RES_VISITED;
            far_r_in  = nr6[CW-1:0];
            far_c_in  = nc6[CW-1:0];
            goal_in   = {nr6[CW-1:0], nc6[CW-1:0]};
         end
      end
      if (cmd.map_wait && res_st_ff == rpmc_pkg::RES_VISITED && map_q_ff) begin
         res_st_in = rpmc_pkg::RES_CARVED;
      end
      if (cmd.shift_wr)  idx_in   = idx_ff + 1'b1;
      if (cmd.shift_end) count_in = count_ff - 1'b1;
      if (cmd.carve_far) begin
         cur_in = {far_r_ff, far_c_ff};
         j_in   = '0;
      end
      if (cmd.add_chk) begin
         j_in = j_ff + 1'b1;
         if (push_ok) count_in = count_ff + 1'b1;
      end
      if (cmd.finish && res_st_ff != rpmc_pkg::RES_IGNORED && count_ff == '0) begin
         active_in = 1'b0;
      end
   end

   // Result register
   always_comb begin
      rv_out_in = rv_out_ff;
      o_st_in   = o_st_ff;
      o_wall_in = o_wall_ff;
      o_fr_in   = o_fr_ff;
      o_fc_in   = o_fc_ff;
      o_pend_in = o_pend_ff;
      o_done_in = o_done_ff;
      o_goal_in = o_goal_ff;
      if (rsp_ready) rv_out_in = 1'b0;
      if (cmd.finish) begin
         rv_out_in = 1'b1;
         o_st_in   = res_st_ff;
         o_wall_in = wall_ff;
         o_fr_in   = far_r_ff;
         o_fc_in   = far_c_ff;
         o_goal_in = goal_ff;
         if (res_st_ff == rpmc_pkg::RES_IGNORED) begin
            o_pend_in = '0;
            o_done_in = 1'b0;
         end else begin
            o_pend_in = count_ff;
            o_done_in = (count_ff == '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff   <= DW'(rpmc_pkg::MAX_DIM);
         cols_ff   <= DW'(rpmc_pkg::MAX_DIM);
         active_ff <= 1'b0;
         count_ff  <= '0;
         goal_ff   <= '0;
         clr_ff    <= '0;
         rv_out_ff <= 1'b0;
      end else begin
         rows_ff   <= rows_in;
         cols_ff   <= cols_in;
         active_ff <= active_in;
         count_ff  <= count_in;
         goal_ff   <= goal_in;
         clr_ff    <= clr_in;
         rv_out_ff <= rv_out_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      sr_ff     <= sr_in;
      sc_ff     <= sc_in;
      rv_ff     <= rv_in;
      res_st_ff <= res_st_in;
      wall_ff   <= wall_in;
      far_r_ff  <= far_r_in;
      far_c_ff  <= far_c_in;
      idx_ff    <= idx_in;
      cur_ff    <= cur_in;
      j_ff      <= j_in;
      o_st_ff   <= o_st_in;
      o_wall_ff <= o_wall_in;
      o_fr_ff   <= o_fr_in;
      o_fc_ff   <= o_fc_in;
      o_pend_ff <= o_pend_in;
      o_done_ff <= o_done_in;
      o_goal_ff <= o_goal_in;
   end

   // Status to the controller
   always_comb begin
      sts.is_start   = (cmd_ff == rpmc_pkg::REQ_START);
      sts.draw_ok    = active_ff && (count_ff != '0);
      sts.clr_last   = (clr_ff == '1);
      sts.div_done   = div_done;
      sts.shift_last = ({1'b0, idx_ff} + 1'b1) == count_ff;
      sts.carve      = (res_st_ff == rpmc_pkg::RES_CARVED);
      sts.add_last   = (j_ff == plan.num);
      sts.rsp_free   = !rv_out_ff || rsp_ready;
   end

   assign rsp_valid         = rv_out_ff;
   assign rsp_status        = o_st_ff;
   assign rsp_wall_row      = o_wall_ff[EW-1:CW];
   assign rsp_wall_col      = o_wall_ff[CW-1:0];
   assign rsp_far_row       = o_fr_ff;
   assign rsp_far_col       = o_fc_ff;
   assign rsp_walls_pending = o_pend_ff;
   assign rsp_done_res      = o_done_ff;
   assign rsp_goal_row      = o_goal_ff[EW-1:CW];
   assign rsp_goal_col      = o_goal_ff[CW-1:0];

endmodule

[sv/rpmc_ctrl.sv]
// Sequencer: steps the datapath through clear, draw, shift, carve and append phases
module rpmc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  rpmc_pkg::dp_sts_type   sts,
   output rpmc_pkg::dp_cmd_type   cmd
);

   rpmc_pkg::state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rpmc_pkg::ST_RST_CLEAR: if (sts.clr_last) state_in = rpmc_pkg::ST_IDLE;
         rpmc_pkg::ST_IDLE:      if (req_valid) state_in = rpmc_pkg::ST_DISPATCH;
         rpmc_pkg::ST_DISPATCH: begin
            if (sts.is_start)     state_in = rpmc_pkg::ST_CLEAR;
            else if (sts.draw_ok) state_in = rpmc_pkg::ST_DIV;
            else                  state_in = rpmc_pkg::ST_FINISH;
         end
         rpmc_pkg::ST_CLEAR:     if (sts.clr_last) state_in = rpmc_pkg::ST_INIT;
         rpmc_pkg::ST_INIT:      state_in = rpmc_pkg::ST_ADD_RD;
         rpmc_pkg::ST_DIV:       if (sts.div_done) state_in = rpmc_pkg::ST_LIST_RD;
         rpmc_pkg::ST_LIST_RD:   state_in = rpmc_pkg::ST_DECODE;
         rpmc_pkg::ST_DECODE:    state_in = rpmc_pkg::ST_MAP_WAIT;
         rpmc_pkg::ST_MAP_WAIT:  state_in = rpmc_pkg::ST_SHIFT_RD;
         rpmc_pkg::ST_SHIFT_RD: begin
            if (!sts.shift_last) state_in = rpmc_pkg::ST_SHIFT_WR;
            else if (sts.carve)  state_in = rpmc_pkg::ST_CARVE_WALL;
            else                 state_in = rpmc_pkg::ST_FINISH;
         end
         rpmc_pkg::ST_SHIFT_WR:   state_in = rpmc_pkg::ST_SHIFT_RD;
         rpmc_pkg::ST_CARVE_WALL: state_in = rpmc_pkg::ST_CARVE_FAR;
         rpmc_pkg::ST_CARVE_FAR:  state_in = rpmc_pkg::ST_ADD_RD;
         rpmc_pkg::ST_ADD_RD: begin
            if (sts.add_last) state_in = rpmc_pkg::ST_FINISH;
            else              state_in = rpmc_pkg::ST_ADD_CHK;
         end
         rpmc_pkg::ST_ADD_CHK:    state_in = rpmc_pkg::ST_ADD_RD;
         rpmc_pkg::ST_FINISH:     if (sts.rsp_free) state_in = rpmc_pkg::ST_IDLE;
         default:                 state_in = rpmc_pkg::ST_IDLE;
      endcase
   end

   // Commands per state
   always_comb begin
      cmd = '0;
      case (state_ff)
         rpmc_pkg::ST_RST_CLEAR: cmd.clr_step  = 1'b1;
         rpmc_pkg::ST_IDLE:      cmd.req_ready = 1'b1;
         rpmc_pkg::ST_DISPATCH: begin
            cmd.dispatch  = 1'b1;
            cmd.div_start = !sts.is_start && sts.draw_ok;
         end
         rpmc_pkg::ST_CLEAR:      cmd.clr_step   = 1'b1;
         rpmc_pkg::ST_INIT:       cmd.start_init = 1'b1;
         rpmc_pkg::ST_LIST_RD:    cmd.list_rd    = 1'b1;
         rpmc_pkg::ST_DECODE:     cmd.decode     = 1'b1;
         rpmc_pkg::ST_MAP_WAIT:   cmd.map_wait   = 1'b1;
         rpmc_pkg::ST_SHIFT_RD:   cmd.shift_end  = sts.shift_last;
         rpmc_pkg::ST_SHIFT_WR:   cmd.shift_wr   = 1'b1;
         rpmc_pkg::ST_CARVE_WALL: cmd.carve_wall = 1'b1;
         rpmc_pkg::ST_CARVE_FAR:  cmd.carve_far  = 1'b1;
         rpmc_pkg::ST_ADD_RD:     cmd.add_rd     = !sts.add_last;
         rpmc_pkg::ST_ADD_CHK:    cmd.add_chk    = 1'b1;
         rpmc_pkg::ST_FINISH:     cmd.finish     = sts.rsp_free;
         default:                 cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rpmc_pkg::ST_RST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/random_prim_maze_carver.sv]
// Randomised Prim maze carver.
// Request channel (req_*): cmd 0 starts a maze at (start_row, start_col),
// cmd 1 makes one random draw from the wall list. Each request gives one
// response on rsp_*. Grid size is set on the csr_* port while idle.
// Work per request:
//   start: the map is cleared one cell a cycle through the single map port,
//          then the walls of the start cell are added.
//   draw:  the remainder divider picks an entry, every later list entry is
//          moved down on removal (one list memory port pair), and the walls
//          of the far cell are added when a cell is carved.
//   draw while idle: the divider is skipped and the response follows.
// One request is in flight at a time; the next one is taken while the last
// response still sits in the output register.
// Reset: a pass over the map sets every map cell to barrier; req_ready stays
// low until it ends. Configuration writes are always taken.
// When rsp_ready is low the response holds and the block waits before
// writing the next response.
module random_prim_maze_carver (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         req_cmd,
   input  logic [4:0]   req_start_row,
   input  logic [4:0]   req_start_col,
   input  logic [30:0]  req_random_value,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [2:0]   rsp_status,
   output logic [4:0]   rsp_wall_row,
   output logic [4:0]   rsp_wall_col,
   output logic [4:0]   rsp_far_row,
   output logic [4:0]   rsp_far_col,
   output logic [12:0]  rsp_walls_pending,
   output logic         rsp_done_res,
   output logic [4:0]   rsp_goal_row,
   output logic [4:0]   rsp_goal_col,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [5:0]   csr_data
);

   rpmc_pkg::dp_cmd_type cmd;
   rpmc_pkg::dp_sts_type sts;

   assign req_ready = cmd.req_ready;
   assign csr_ready = 1'b1;

   rpmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   rpmc_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_valid         (req_valid),
      .req_cmd           (req_cmd),
      .req_start_row     (req_start_row),
      .req_start_col     (req_start_col),
      .req_random_value  (req_random_value),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_wall_row      (rsp_wall_row),
      .rsp_wall_col      (rsp_wall_col),
      .rsp_far_row       (rsp_far_row),
      .rsp_far_col       (rsp_far_col),
      .rsp_walls_pending (rsp_walls_pending),
      .rsp_done_res      (rsp_done_res),
      .rsp_goal_row      (rsp_goal_row),
      .rsp_goal_col      (rsp_goal_col)
   );

endmodule

[sv/rpmc_checker.sv]
`include "random_prim_maze_carver_assert.svh"

// Port-level checks on the response channel
module rpmc_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  logic [2:0]   rsp_status,
   input  logic [4:0]   rsp_wall_row,
   input  logic [4:0]   rsp_wall_col,
   input  logic [4:0]   rsp_far_row,
   input  logic [4:0]   rsp_far_col,
   input  logic [12:0]  rsp_walls_pending,
   input  logic         rsp_done_res,
   input  logic [4:0]   rsp_goal_row,
   input  logic [4:0]   rsp_goal_col
);

   logic is_ignored, is_edge, far_in_grid;
   logic idle_zero, far_zero, goal_is_far;

   // Response kinds and field groups
   assign is_ignored  = rsp_valid && (rsp_status == rpmc_pkg::RES_IGNORED);
   assign is_edge     = rsp_valid && (rsp_status == rpmc_pkg::RES_EDGE_REMOVED);
   assign far_in_grid = rsp_valid && ((rsp_status == rpmc_pkg::RES_CARVED) ||
                                      (rsp_status == rpmc_pkg::RES_VISITED));
   assign far_zero    = (rsp_far_row == '0) && (rsp_far_col == '0);
   assign idle_zero   = (rsp_walls_pending == '0) && !rsp_done_res &&
                        (rsp_wall_row == '0) && (rsp_wall_col == '0) && far_zero;
   assign goal_is_far = (rsp_goal_row == rsp_far_row) && (rsp_goal_col == rsp_far_col);

   // A finished maze has an empty list
   `RPMC_ASSERT_SAME(a_done_empty, rsp_valid && rsp_done_res, rsp_walls_pending == '0)

   // An ignored draw reports nothing but the goal
   `RPMC_ASSERT_SAME(a_idle_zero, is_ignored, idle_zero)

   // Outside far cell reads as zero
   `RPMC_ASSERT_SAME(a_edge_far, is_edge, far_zero)

   // An in-grid far cell becomes the goal
   `RPMC_ASSERT_SAME(a_goal_far, far_in_grid, goal_is_far)

   // A stalled response holds
   `RPMC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status))

endmodule

bind random_prim_maze_carver rpmc_checker u_rpmc_checker (.*);
